[sv/ptw_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and widths for the x86 page-table walker.
// No dependencies; every other file imports this package.
package ptw_pkg;

	// Implemented virtual address width in long mode; the bits above it must match its sign bit.
	localparam int CANON_BITS = 48;
	localparam int CANON_TOP_W = 65 - CANON_BITS;

	localparam int VADDR_W = 64;
	localparam int ENTRY_W = 64;
	localparam int PADDR_W = 52;
	localparam int LEFT_W = 23;
	localparam int CFG_W = 32;

	localparam logic [LEFT_W-1:0] SIZE_4K = LEFT_W'(32'h0000_1000);
	localparam logic [LEFT_W-1:0] SIZE_2M = LEFT_W'(32'h0020_0000);
	localparam logic [LEFT_W-1:0] SIZE_4M = LEFT_W'(32'h0040_0000);

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_ENTRY = 1'b1
	} cmd_t;

	typedef enum logic {
		CFG_TABLE_ROOT = 1'b0,
		CFG_LONG_MODE  = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_FAULT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CAUSE_NONE   = 2'd0,
		CAUSE_RANGE  = 2'd1,
		CAUSE_ABSENT = 2'd2,
		CAUSE_DATA   = 2'd3
	} cause_t;

	// Walk position: which entry the block waits for.
	typedef enum logic [2:0] {
		LVL_IDLE = 3'd0,
		LVL_PT64 = 3'd1,
		LVL_PD64 = 3'd2,
		LVL_PDPT = 3'd3,
		LVL_PML4 = 3'd4,
		LVL_PT32 = 3'd5,
		LVL_PD32 = 3'd6
	} level_t;

	typedef struct packed {
		cmd_t               command;
		logic [VADDR_W-1:0] vaddr;
		logic [ENTRY_W-1:0] entry_data;
	} in_word_t;

	typedef struct packed {
		kind_t              kind;
		logic [PADDR_W-1:0] read_address;
		logic               entry_wide;
		logic [PADDR_W-1:0] page_address;
		logic [LEFT_W-1:0]  bytes_left;
		logic               large_page;
		cause_t             fault_cause;
	} out_word_t;

	typedef struct packed {
		level_t             level;
		logic [VADDR_W-1:0] vaddr;
	} walk_state_t;

endpackage

[sv/ptw_req_if.sv]
`timescale 1ns / 1ps
// Request channel of the walker: start commands and returned entries.
// Depends on ptw_pkg for field widths.
interface ptw_req_if;
	import ptw_pkg::*;

	logic               valid;
	logic               ready;
	logic               command;
	logic [VADDR_W-1:0] vaddr;
	logic [ENTRY_W-1:0] entry_data;

	modport source (output valid, command, vaddr, entry_data, input ready);
	modport sink (input valid, command, vaddr, entry_data, output ready);

endinterface

[sv/ptw_rsp_if.sv]
`timescale 1ns / 1ps
// Result channel of the walker: read requests, translations and faults.
// Depends on ptw_pkg for field widths.
interface ptw_rsp_if;
	import ptw_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [PADDR_W-1:0] read_address;
	logic               entry_wide;
	logic [PADDR_W-1:0] page_address;
	logic [LEFT_W-1:0]  bytes_left;
	logic               large_page;
	logic [1:0]         fault_cause;

	modport source (output valid, kind, read_address, entry_wide, page_address,
		bytes_left, large_page, fault_cause, input ready);
	modport sink (input valid, kind, read_address, entry_wide, page_address,
		bytes_left, large_page, fault_cause, output ready);

endinterface

[sv/ptw_step.sv]
`timescale 1ns / 1ps
// One walk step: decodes a word against the walk state, builds the result
// word and the next walk state. Depends on ptw_pkg.
module ptw_step (
	input  ptw_pkg::in_word_t    word,
	input  ptw_pkg::walk_state_t cur,
	input  logic [31:0]          table_root,
	input  logic                 long_mode,
	output ptw_pkg::out_word_t   res,
	output ptw_pkg::walk_state_t nxt
);
	import ptw_pkg::*;

	logic [VADDR_W-1:0]     v;
	logic [ENTRY_W-1:0]     e;
	logic [PADDR_W-1:0]     root;
	logic [PADDR_W-1:0]     tbl64;
	logic [PADDR_W-1:0]     big64;
	logic [PADDR_W-1:0]     tbl32;
	logic [PADDR_W-1:0]     big32;
	logic [CANON_TOP_W-1:0] top;
	logic                   present;
	logic                   large64;
	logic                   present32;
	logic                   large32;

	// A start command translates its own address; entries use the saved one.
	assign v = (word.command == CMD_START) ? word.vaddr : cur.vaddr;
	assign e = word.entry_data;
	assign top = v[VADDR_W-1:CANON_BITS-1];

	assign root  = {20'b0, table_root[31:12], 12'b0};
	assign tbl64 = {e[51:12], 12'b0};
	assign big64 = {e[51:21], 21'b0};
	assign tbl32 = {20'b0, e[31:12], 12'b0};
	assign big32 = {20'b0, e[31:22], 22'b0};

	assign present   = e[0];
	assign large64   = e[7];
	assign present32 = e[0];
	assign large32   = e[7];

	always_comb begin
		res = '0;
		res.kind = KIND_READ;
		res.fault_cause = CAUSE_NONE;
		nxt.vaddr = v;
		nxt.level = LVL_IDLE;

		if (word.command == CMD_START) begin
			if (long_mode) begin
				if (top != '0 && top != '1) begin
					res.kind = KIND_FAULT;
					res.fault_cause = CAUSE_RANGE;
				end else begin
					res.read_address = root + {40'b0, v[47:39], 3'b0};
					res.entry_wide = 1'b1;
					nxt.level = LVL_PML4;
				end
			end else begin
				if (v[63:32] != '0) begin
					res.kind = KIND_FAULT;
					res.fault_cause = CAUSE_RANGE;
				end else begin
					res.read_address = root + {40'b0, v[31:22], 2'b0};
					nxt.level = LVL_PD32;
				end
			end
		end else begin
			unique case (cur.level)
				LVL_PML4, LVL_PDPT, LVL_PD64, LVL_PT64, LVL_PD32, LVL_PT32: begin
					if (!present) begin
						res.kind = KIND_FAULT;
						res.fault_cause = CAUSE_ABSENT;
					end else begin
						unique case (cur.level)
							LVL_PML4: begin
								res.read_address = tbl64 + {40'b0, v[38:30], 3'b0};
								res.entry_wide = 1'b1;
								nxt.level = LVL_PDPT;
							end
							LVL_PDPT: begin
								res.read_address = tbl64 + {40'b0, v[29:21], 3'b0};
								res.entry_wide = 1'b1;
								nxt.level = LVL_PD64;
							end
							LVL_PD64: begin
								if (large64) begin
									res.kind = KIND_DONE;
									res.page_address = big64 + {31'b0, v[20:0]};
									res.bytes_left = SIZE_2M - {2'b0, v[20:0]};
									res.large_page = 1'b1;
								end else begin
									res.read_address = tbl64 + {40'b0, v[20:12], 3'b0};
									res.entry_wide = 1'b1;
									nxt.level = LVL_PT64;
								end
							end
							LVL_PT64: begin
								res.kind = KIND_DONE;
								res.page_address = tbl64 + {40'b0, v[11:0]};
								res.bytes_left = SIZE_4K - {11'b0, v[11:0]};
							end
							LVL_PD32: begin
								if (large32) begin
									res.kind = KIND_DONE;
									res.page_address = big32 + {30'b0, v[21:0]};
									res.bytes_left = SIZE_4M - {1'b0, v[21:0]};
									res.large_page = 1'b1;
								end else begin
									res.read_address = tbl32 + {40'b0, v[21:12], 2'b0};
									nxt.level = LVL_PT32;
								end
							end
							default: begin
								res.kind = KIND_DONE;
								res.page_address = tbl32 + {40'b0, v[11:0]};
								res.bytes_left = SIZE_4K - {11'b0, v[11:0]};
							end
						endcase
					end
				end
				default: begin
					res.kind = KIND_FAULT;
					res.fault_cause = CAUSE_DATA;
				end
			endcase
		end
	end

endmodule

[sv/x86_page_table_walker.sv]
`timescale 1ns / 1ps
// Top level of the x86 page-table walker: input register, walk state,
// result register and configuration. Depends on ptw_pkg, ptw_req_if,
// ptw_rsp_if and ptw_step.
//
//   channel  dir  words carried
//   -------  ---  -------------------------------------------------------
//   req      in   start command with vaddr, or returned entry_data
//   rsp      out  entry read request, translation done, or fault
//   cfg      in   write-only register port (table_root, long_mode)
//
// One word per cycle sustained while rsp is ready; a result is presented once its
// request word has passed the input register, then the result register.
// The walk state updates as a word moves from the input register into the
// result register, so the next word decodes against the updated state.
// Reset clears the walk to idle, the saved address and both config registers.
// A stalled result holds in the result register; the input register keeps
// taking words whenever it empties or advances in the same cycle.
module x86_page_table_walker (
	input  logic                          clk,
	input  logic                          arst_n,
	ptw_req_if.sink                       req,
	ptw_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  ptw_pkg::cfg_index_t           cfg_index,
	input  logic [ptw_pkg::CFG_W-1:0]     cfg_data
);
	import ptw_pkg::*;

	logic        valid_s1;
	in_word_t    word_s1;
	logic        rsp_valid_q;
	out_word_t   rsp_word_q;
	walk_state_t walk_q;
	logic [31:0] table_root_q;
	logic        long_mode_q;

	out_word_t   step_res;
	walk_state_t step_nxt;
	logic        advance;
	logic        take;

	// Advance the input word when the result register is empty or draining.
	assign advance = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign take = req.valid && req.ready;

	ptw_step u_step (
		.word       (word_s1),
		.cur        (walk_q),
		.table_root (table_root_q),
		.long_mode  (long_mode_q),
		.res        (step_res),
		.nxt        (step_nxt)
	);

	// Input register: payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s1.command    <= cmd_t'(req.command);
			word_s1.vaddr      <= req.vaddr;
			word_s1.entry_data <= req.entry_data;
		end
	end

	// Result register and walk state move together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			walk_q <= '{level: LVL_IDLE, vaddr: '0};
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
			walk_q <= step_nxt;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_word_q <= step_res;
		end
	end

	// Configuration writes must arrive only while the walker is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_root_q <= '0;
			long_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TABLE_ROOT: table_root_q <= cfg_data;
				CFG_LONG_MODE:  long_mode_q <= cfg_data[0];
				default:        long_mode_q <= long_mode_q;
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.kind         = rsp_word_q.kind;
	assign rsp.read_address = rsp_word_q.read_address;
	assign rsp.entry_wide   = rsp_word_q.entry_wide;
	assign rsp.page_address = rsp_word_q.page_address;
	assign rsp.bytes_left   = rsp_word_q.bytes_left;
	assign rsp.large_page   = rsp_word_q.large_page;
	assign rsp.fault_cause  = rsp_word_q.fault_cause;

endmodule
